// File: src/art_pkg.sv
package art_pkg;

    localparam int ID_BITS    = 32;
    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    typedef logic [ID_BITS-1:0] t_id;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_REVERSE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_WRITE,
        TBL_INSERT,
        TBL_DELETE
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op           op;
        logic [IDX_W-1:0]  idx;
        t_id               wr_s;
        t_id               wr_e;
    } t_tbl_cmd;

    typedef struct packed {
        t_id a_s;
        t_id a_e;
        t_id b_s;
        t_id b_e;
        t_id x;
    } t_cmp_in;

    typedef struct packed {
        logic a_rev;
        logic e_lt_x;
        logic e_le_x;
        logic in_x;
        logic join_x;
        logic meet;
        logic b_before_a;
        t_id  new_s;
        t_id  new_e;
    } t_cmp_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_POP,
        S_MARKJ,
        S_LOADW,
        S_COAL,
        S_QMARK,
        S_QSCAN,
        S_DONE
    } t_state;

    function automatic logic ser_lt(input t_id a, input t_id b);
        t_id d;
        d = a - b;
        return d[ID_BITS-1];
    endfunction

    function automatic logic ser_le(input t_id a, input t_id b);
        return (a == b) || ser_lt(a, b);
    endfunction

    function automatic logic in_rng(input t_id s, input t_id e, input t_id x);
        return ser_le(s, x) && ser_le(x, e);
    endfunction

endpackage

// File: src/art_table.sv
module art_table
    import art_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_cmd         i_cmd,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_id              o_rd_s,
    output t_id              o_rd_e
);

    t_id r_start [MAX_RANGES];
    t_id r_end   [MAX_RANGES];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RANGES; j++) begin
            unique case (i_cmd.op)
                TBL_WRITE: begin
                    if (IDX_W'(j) == i_cmd.idx) begin
                        r_start[j] <= i_cmd.wr_s;
                        r_end[j]   <= i_cmd.wr_e;
                    end
                end
                TBL_INSERT: begin
                    if (IDX_W'(j) == i_cmd.idx) begin
                        r_start[j] <= i_cmd.wr_s;
                        r_end[j]   <= i_cmd.wr_e;
                    end else if (j > 0 && IDX_W'(j) > i_cmd.idx) begin
                        r_start[j] <= r_start[(j > 0) ? j - 1 : 0];
                        r_end[j]   <= r_end[(j > 0) ? j - 1 : 0];
                    end
                end
                TBL_DELETE: begin
                    if (j < MAX_RANGES - 1 && IDX_W'(j) >= i_cmd.idx) begin
                        r_start[j] <= r_start[(j < MAX_RANGES - 1) ? j + 1 : j];
                        r_end[j]   <= r_end[(j < MAX_RANGES - 1) ? j + 1 : j];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_rd_s = r_start[i_rd_idx];
    assign o_rd_e = r_end[i_rd_idx];

endmodule

// File: src/art_cmp.sv
module art_cmp
    import art_pkg::*;
(
    input  t_cmp_in  i_op,
    output t_cmp_out o_res
);

    t_id d_ax;
    t_id d_ab;
    t_id d_ba;

    always_comb begin
        d_ax = i_op.a_s - i_op.x;
        d_ab = i_op.a_s - i_op.b_e;
        d_ba = i_op.b_s - i_op.a_e;

        o_res.a_rev      = ser_lt(i_op.a_e, i_op.a_s);
        o_res.e_lt_x     = ser_lt(i_op.a_e, i_op.x);
        o_res.e_le_x     = ser_le(i_op.a_e, i_op.x);
        o_res.in_x       = in_rng(i_op.a_s, i_op.a_e, i_op.x);
        o_res.join_x     = o_res.in_x || (d_ax == t_id'(1));
        o_res.meet       = in_rng(i_op.b_s, i_op.b_e, i_op.a_s)
                        || in_rng(i_op.b_s, i_op.b_e, i_op.a_e)
                        || in_rng(i_op.a_s, i_op.a_e, i_op.b_s)
                        || in_rng(i_op.a_s, i_op.a_e, i_op.b_e)
                        || (d_ab == t_id'(1)) || (d_ba == t_id'(1));
        o_res.b_before_a = ser_lt(i_op.b_s, i_op.a_s);
        o_res.new_s      = o_res.b_before_a ? i_op.b_s : i_op.a_s;
        o_res.new_e      = ser_lt(i_op.a_e, i_op.b_e) ? i_op.b_e : i_op.a_e;
    end

endmodule

// File: src/ack_range_set_tracker_unit.sv
// a clear or an unused operation goes from idle straight to done; o_done is registered from done
// add states: check, scan, pop, mark-join, load, coalesce; query states: mark check, scan
// one table entry is examined or removed per cycle by the shared compare unit
// throughput: one transaction at a time, busy is high from acceptance until the result cycle
// o_done pulses for one cycle; results hold until the next o_done, the receiver cannot stall
// reset: synchronous active low, mark and range count cleared, table contents left as is
module ack_range_set_tracker_unit
    import art_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_operation,
    input  logic [31:0]      i_first_id,
    input  logic [31:0]      i_last_id,
    input  logic [31:0]      i_query_id,
    output logic             o_done,
    output logic             o_covered,
    output logic [31:0]      o_acked_mark,
    output logic [4:0]       o_ranges_held,
    output logic [1:0]       o_status
);

    t_state r_state, n_state;
    t_id r_mark, n_mark;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_mi, n_mi;
    logic [CNT_W-1:0] r_pops, n_pops;
    logic r_mark_case, n_mark_case;
    logic r_merged, n_merged;
    logic r_covered, n_covered;
    t_status r_status, n_status;
    t_id r_f, r_l, r_q;
    t_id r_ws, n_ws, r_we, n_we;
    logic r_done;
    logic r_o_cov;
    t_id r_o_mark;
    logic [CNT_W-1:0] r_o_cnt;
    t_status r_o_status;

    t_tbl_cmd cmd;
    logic [CNT_W-1:0] rd_addr;
    t_id rd_s, rd_e;
    t_cmp_in cin;
    t_cmp_out cres;
    logic full;
    logic [CNT_W-1:0] mi_next;
    logic [CNT_W-1:0] mi_adj;

    art_table u_table (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_rd_idx(rd_addr[IDX_W-1:0]),
        .o_rd_s  (rd_s),
        .o_rd_e  (rd_e)
    );

    art_cmp u_cmp (
        .i_op (cin),
        .o_res(cres)
    );

    assign full    = (r_cnt == CNT_W'(MAX_RANGES));
    assign mi_next = r_mi + CNT_W'(1);
    assign mi_adj  = (r_mark_case || r_mi < r_pops) ? '0 : r_mi - r_pops;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark  <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mark  <= n_mark;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_mi        <= n_mi;
        r_pops      <= n_pops;
        r_mark_case <= n_mark_case;
        r_merged    <= n_merged;
        r_covered   <= n_covered;
        r_status    <= n_status;
        r_ws        <= n_ws;
        r_we        <= n_we;
        if (r_state == S_IDLE && start) begin
            r_f <= i_first_id;
            r_l <= i_last_id;
            r_q <= i_query_id;
        end
        if (r_state == S_DONE) begin
            r_o_cov    <= r_covered;
            r_o_mark   <= r_mark;
            r_o_cnt    <= r_cnt;
            r_o_status <= r_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mark      = r_mark;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_mi        = r_mi;
        n_pops      = r_pops;
        n_mark_case = r_mark_case;
        n_merged    = r_merged;
        n_covered   = r_covered;
        n_status    = r_status;
        n_ws        = r_ws;
        n_we        = r_we;
        cmd         = '{op: TBL_NOP, idx: '0, wr_s: '0, wr_e: '0};
        rd_addr     = r_idx;
        cin         = '{a_s: rd_s, a_e: rd_e, b_s: r_f, b_e: r_l, x: r_mark};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status    = ST_OK;
                    n_covered   = 1'b0;
                    n_pops      = '0;
                    n_idx       = '0;
                    n_mi        = '0;
                    n_mark_case = 1'b0;
                    n_merged    = 1'b0;
                    unique case (t_op'(i_operation))
                        OP_ADD:   n_state = S_CHECK;
                        OP_QUERY: n_state = S_QMARK;
                        OP_CLEAR: begin
                            n_mark  = '0;
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CHECK: begin
                cin.a_s = r_f;
                cin.a_e = r_l;
                priority if (cres.a_rev) begin
                    n_status = ST_REVERSE;
                    n_state  = S_DONE;
                end else if (cres.e_lt_x) begin
                    n_state = S_DONE;
                end else if (cres.join_x) begin
                    n_mark      = r_l;
                    n_mark_case = 1'b1;
                    n_merged    = 1'b1;
                    n_state     = S_POP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (r_idx == r_cnt) begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        cmd   = '{op: TBL_INSERT, idx: r_cnt[IDX_W-1:0], wr_s: r_f, wr_e: r_l};
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = S_DONE;
                end else if (cres.meet) begin
                    cmd = '{op: TBL_WRITE, idx: r_idx[IDX_W-1:0],
                            wr_s: cres.new_s, wr_e: cres.new_e};
                    n_mi     = r_idx;
                    n_merged = 1'b1;
                    n_state  = S_POP;
                end else if (cres.b_before_a) begin
                    if (full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        cmd   = '{op: TBL_INSERT, idx: r_idx[IDX_W-1:0], wr_s: r_f, wr_e: r_l};
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_state = S_POP;
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_POP: begin
                rd_addr = '0;
                priority if (r_cnt != '0 && cres.e_le_x) begin
                    cmd    = '{op: TBL_DELETE, idx: '0, wr_s: '0, wr_e: '0};
                    n_cnt  = r_cnt - CNT_W'(1);
                    n_pops = r_pops + CNT_W'(1);
                end else if (!r_merged) begin
                    n_state = S_DONE;
                end else begin
                    n_mi    = mi_adj;
                    n_state = (mi_adj == '0) ? S_MARKJ : S_LOADW;
                end
            end
            S_MARKJ: begin
                rd_addr = '0;
                if (r_cnt != '0 && cres.join_x) begin
                    n_mark = rd_e;
                    cmd    = '{op: TBL_DELETE, idx: '0, wr_s: '0, wr_e: '0};
                    n_cnt  = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_LOADW;
                end
            end
            S_LOADW: begin
                rd_addr = r_mi;
                n_ws    = rd_s;
                n_we    = rd_e;
                n_state = S_COAL;
            end
            S_COAL: begin
                rd_addr = mi_next;
                cin.a_s = r_ws;
                cin.a_e = r_we;
                cin.b_s = rd_s;
                cin.b_e = rd_e;
                if (mi_next < r_cnt && cres.meet) begin
                    n_ws  = cres.new_s;
                    n_we  = cres.new_e;
                    cmd   = '{op: TBL_DELETE, idx: mi_next[IDX_W-1:0], wr_s: '0, wr_e: '0};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    if (r_mi < r_cnt) begin
                        cmd = '{op: TBL_WRITE, idx: r_mi[IDX_W-1:0], wr_s: r_ws, wr_e: r_we};
                    end
                    n_state = S_DONE;
                end
            end
            S_QMARK: begin
                cin.a_e = r_q;
                if (cres.e_le_x) begin
                    n_covered = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = S_QSCAN;
                end
            end
            S_QSCAN: begin
                cin.x = r_q;
                priority if (r_idx == r_cnt) begin
                    n_state = S_DONE;
                end else if (cres.in_x) begin
                    n_covered = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_covered     = r_o_cov;
    assign o_acked_mark  = r_o_mark;
    assign o_ranges_held = r_o_cnt;
    assign o_status      = r_o_status;

endmodule
